FILE: rtl/clrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clrl_pkg
// Shared widths, stop codes and parse phase type for the cluster run list
// decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package clrl_pkg;

   // Field widths of the request and response transactions.
   localparam int DATA_W    = 8;
   localparam int LIST_LEN_W = 13;
   localparam int CLUSTER_W = 64;
   localparam int CAUSE_W   = 2;
   localparam int NIBBLE_W  = 4;

   // Reasons why parsing of a list stopped.
   typedef enum logic [CAUSE_W-1:0] {
      STOP_ZERO_HEADER = 2'd0,
      STOP_BAD_HEADER  = 2'd1,
      STOP_LEN_USED    = 2'd2
   } stop_cause_type;

   // Parse phase, one-hot.
   typedef enum logic [3:0] {
      PH_STOPPED = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_COUNT   = 4'b0100,
      PH_OFFSET  = 4'b1000
   } phase_type;

endpackage : clrl_pkg
`default_nettype wire

FILE: rtl/clrl_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clrl channel interfaces
// Valid/ready channels for run list bytes in and decoded runs out.
// ----------------------------------------------------------------------------

// One run list byte per transaction.
interface clrl_req_if;
   logic                              valid;
   logic                              ready;
   logic [clrl_pkg::DATA_W-1:0]       data_byte;
   logic                              list_start;
   logic [clrl_pkg::LIST_LEN_W-1:0]   list_length;

   modport source (output valid, output data_byte, output list_start,
                   output list_length, input ready);
   modport sink   (input valid, input data_byte, input list_start,
                   input list_length, output ready);
endinterface : clrl_req_if

// One decoded run or stop report per transaction.
interface clrl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [clrl_pkg::CLUSTER_W-1:0]    run_start_cluster;
   logic [clrl_pkg::CLUSTER_W-1:0]    run_cluster_count;
   logic                              carries_run;
   logic                              list_done;
   logic [clrl_pkg::CAUSE_W-1:0]      stop_cause;

   modport source (output valid, output run_start_cluster, output run_cluster_count,
                   output carries_run, output list_done, output stop_cause,
                   input ready);
   modport sink   (input valid, input run_start_cluster, input run_cluster_count,
                   input carries_run, input list_done, input stop_cause,
                   output ready);
endinterface : clrl_rsp_if
`default_nettype wire

FILE: rtl/cluster_run_list_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_run_list_decoder
// Streaming decoder for a file-system run list: one byte per transaction,
// emits absolute run start cluster and cluster count, and reports list stops.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Transaction
//   req_ch    in    data_byte, list_start, list_length
//   rsp_ch    out   run_start_cluster, run_cluster_count, carries_run,
//                   list_done, stop_cause
//
// A byte is accepted every cycle unless the response stalls; its result, if any,
// is decoded from the input register and loaded into the result register, from
// which it can be taken (input register, then result register).
// The rate is set by the combinational decode step, whose longest path is the
// 64-bit add of the sign-extended offset delta to the start cluster.
// Synchronous active-high reset empties both registers and stops parsing.
// A stalled response holds the result register; the input register then
// fills and req_ch.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module cluster_run_list_decoder #(
   parameter int MAX_LIST_BYTES = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   clrl_req_if.sink    req_ch,
   clrl_rsp_if.source  rsp_ch
);

   localparam int LEN_W = $clog2(MAX_LIST_BYTES + 1);
   localparam int CW    = clrl_pkg::CLUSTER_W;

   // Input register.
   logic                               in_valid_ff;
   logic [clrl_pkg::DATA_W-1:0]        in_byte_ff;
   logic                               in_start_ff;
   logic [clrl_pkg::LIST_LEN_W-1:0]    in_len_ff;

   // Decoder state.
   clrl_pkg::phase_type                phase_ff, phase_in, phase_eff;
   logic [LEN_W-1:0]                   pos_ff, pos_in, pos_eff, pos_inc;
   logic [LEN_W-1:0]                   held_ff, held_in, held_eff;
   logic [clrl_pkg::NIBBLE_W-1:0]      lsz_ff, lsz_in, osz_ff, osz_in;
   logic [clrl_pkg::NIBBLE_W-1:0]      idx_ff, idx_in;
   logic [CW-1:0]                      cluster_ff, cluster_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      delta_ff, delta_in;

   // Result register.
   logic                               rsp_valid_ff;
   logic [CW-1:0]                      rsp_start_ff, rsp_count_ff;
   logic                               rsp_run_ff, rsp_done_ff;
   clrl_pkg::stop_cause_type           rsp_cause_ff;

   // Decode step outputs.
   logic                               advance;
   logic                               emit;
   logic                               res_run;
   logic                               res_done;
   clrl_pkg::stop_cause_type           res_cause;
   logic [CW-1:0]                      res_start;

   logic [31:0]                        len_ext, clamp_len;
   logic [LEN_W:0]                     hdr_sum;
   logic [clrl_pkg::NIBBLE_W:0]        idx_next;
   logic [CW-1:0]                      field_word;
   logic [CW-1:0]                      delta_next;
   logic [CW-1:0]                      cluster_next;
   logic                               list_end;

   // Handshake: the input register advances when the result register is free.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // List length clamped to the largest supported list.
   assign len_ext   = {{(32 - clrl_pkg::LIST_LEN_W){1'b0}}, in_len_ff};
   assign clamp_len = (len_ext > 32'(MAX_LIST_BYTES)) ? 32'(MAX_LIST_BYTES) : len_ext;

   // Current byte placed in its little-endian lane of the field.
   assign field_word = CW'(in_byte_ff) << {idx_ff[2:0], 3'b000};

   // Decode one byte.
   always_comb begin
      held_eff    = held_ff;
      pos_eff     = pos_ff;
      phase_eff   = phase_ff;
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      held_in     = held_ff;
      lsz_in      = lsz_ff;
      osz_in      = osz_ff;
      idx_in      = idx_ff;
      cluster_in  = cluster_ff;
      count_in    = count_ff;
      delta_in    = delta_ff;
      emit        = 1'b0;
      res_run     = 1'b0;
      res_done    = 1'b0;
      res_cause   = clrl_pkg::STOP_ZERO_HEADER;
      res_start   = '0;
      delta_next  = delta_ff;
      cluster_next = cluster_ff;
      idx_next    = {1'b0, idx_ff} + 5'd1;

      // A list start restarts position and start cluster.
      if (in_start_ff) begin
         held_eff   = clamp_len[LEN_W-1:0];
         pos_eff    = '0;
         phase_eff  = clrl_pkg::PH_HEADER;
         held_in    = held_eff;
         pos_in     = '0;
         cluster_in = '0;
         phase_in   = clrl_pkg::PH_HEADER;
         if (held_eff == '0) begin
            emit      = 1'b1;
            res_done  = 1'b1;
            res_cause = clrl_pkg::STOP_LEN_USED;
            phase_eff = clrl_pkg::PH_STOPPED;
            phase_in  = clrl_pkg::PH_STOPPED;
         end
      end

      pos_inc  = pos_eff + LEN_W'(1);
      hdr_sum  = {1'b0, pos_inc} + (LEN_W + 1)'(in_byte_ff[3:0])
                 + (LEN_W + 1)'(in_byte_ff[7:4]);
      list_end = (pos_inc >= held_eff);

      unique case (phase_eff)
         clrl_pkg::PH_STOPPED: begin
         end
         clrl_pkg::PH_HEADER: begin
            pos_in = pos_inc;
            if (in_byte_ff == '0) begin
               emit      = 1'b1;
               res_done  = 1'b1;
               res_cause = clrl_pkg::STOP_ZERO_HEADER;
               phase_in  = clrl_pkg::PH_STOPPED;
            end else begin
               lsz_in = in_byte_ff[3:0];
               osz_in = in_byte_ff[7:4];
               if (in_byte_ff[3:0] == '0 || hdr_sum > {1'b0, held_eff}) begin
                  emit      = 1'b1;
                  res_done  = 1'b1;
                  res_cause = clrl_pkg::STOP_BAD_HEADER;
                  phase_in  = clrl_pkg::PH_STOPPED;
               end else begin
                  idx_in   = '0;
                  count_in = '0;
                  delta_in = '0;
                  phase_in = clrl_pkg::PH_COUNT;
               end
            end
         end
         clrl_pkg::PH_COUNT: begin
            pos_in = pos_inc;
            // Fields longer than eight bytes are consumed but read as zero.
            if (lsz_ff <= 4'd8) begin
               count_in = count_ff | field_word;
            end
            if (idx_next < {1'b0, lsz_ff}) begin
               idx_in = idx_next[clrl_pkg::NIBBLE_W-1:0];
            end else begin
               idx_in = '0;
               if (osz_ff == '0) begin
                  // Sparse run: nothing emitted, start cluster unchanged.
                  if (list_end) begin
                     emit      = 1'b1;
                     res_done  = 1'b1;
                     res_cause = clrl_pkg::STOP_LEN_USED;
                     phase_in  = clrl_pkg::PH_STOPPED;
                  end else begin
                     phase_in = clrl_pkg::PH_HEADER;
                  end
               end else begin
                  phase_in = clrl_pkg::PH_OFFSET;
               end
            end
         end
         clrl_pkg::PH_OFFSET: begin
            pos_in = pos_inc;
            if (osz_ff <= 4'd8) begin
               delta_next = delta_ff | field_word;
            end
            if (idx_next < {1'b0, osz_ff}) begin
               idx_in   = idx_next[clrl_pkg::NIBBLE_W-1:0];
               delta_in = delta_next;
            end else begin
               idx_in = '0;
               // Sign-extend a delta shorter than eight bytes.
               if (in_byte_ff[7] && osz_ff < 4'd8) begin
                  delta_next = delta_next | ({CW{1'b1}} << {osz_ff[2:0], 3'b000});
               end
               delta_in     = delta_next;
               cluster_next = cluster_ff + delta_next;
               cluster_in   = cluster_next;
               res_run      = (count_ff != '0);
               res_start    = cluster_next;
               if (list_end) begin
                  emit      = 1'b1;
                  res_done  = 1'b1;
                  res_cause = clrl_pkg::STOP_LEN_USED;
                  phase_in  = clrl_pkg::PH_STOPPED;
               end else begin
                  emit     = res_run;
                  phase_in = clrl_pkg::PH_HEADER;
               end
            end
         end
         default: begin
            phase_in = clrl_pkg::PH_STOPPED;
         end
      endcase
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff  <= req_ch.data_byte;
         in_start_ff <= req_ch.list_start;
         in_len_ff   <= req_ch.list_length;
      end
   end

   // Decoder state, updated once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= clrl_pkg::PH_STOPPED;
         pos_ff   <= '0;
         held_ff  <= '0;
         idx_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         idx_ff   <= idx_in;
      end
      if (advance) begin
         lsz_ff     <= lsz_in;
         osz_ff     <= osz_in;
         cluster_ff <= cluster_in;
         count_ff   <= count_in;
         delta_ff   <= delta_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_start_ff <= res_run ? res_start : '0;
         rsp_count_ff <= res_run ? count_ff : '0;
         rsp_run_ff   <= res_run;
         rsp_done_ff  <= res_done;
         rsp_cause_ff <= res_done ? res_cause : clrl_pkg::STOP_ZERO_HEADER;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.run_start_cluster = rsp_start_ff;
   assign rsp_ch.run_cluster_count = rsp_count_ff;
   assign rsp_ch.carries_run       = rsp_run_ff;
   assign rsp_ch.list_done         = rsp_done_ff;
   assign rsp_ch.stop_cause        = rsp_cause_ff;

`ifndef SYNTHESIS
   // A result that carries a run never has a zero cluster count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_run_ff |-> rsp_count_ff != '0)
      else $error("run emitted with zero cluster count");

   // The position never passes the held list length while parsing.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != clrl_pkg::PH_STOPPED |-> pos_ff <= held_ff)
      else $error("byte position beyond list length");

   // A stop report leaves the decoder stopped.
   assert property (@(posedge clock) disable iff (reset)
      advance && emit && res_done |=> phase_ff == clrl_pkg::PH_STOPPED)
      else $error("decoder not stopped after list stop");

   // A byte waiting in the input register is not dropped under a stall.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input byte lost");

   // A pending result is not overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !advance)
      else $error("result register overwritten while stalled");
`endif

endmodule : cluster_run_list_decoder
`default_nettype wire
